// File: sv/min_priority_queue_macros.svh
// Assertion macros used by the priority queue top level.
`ifndef MIN_PRIORITY_QUEUE_MACROS_SVH
`define MIN_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MPQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define MPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/mpq_pkg.sv
// Shared types and codes of the priority queue.
package mpq_pkg;

    // request actions
    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_STATUS = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_REJECT = 2'd3;

    // datapath store operations
    localparam logic [1:0] OP_NONE = 2'd0;
    localparam logic [1:0] OP_PUT  = 2'd1;
    localparam logic [1:0] OP_TAKE = 2'd2;

    // reported for an empty queue; keys at or above it are refused
    localparam logic signed [31:0] EMPTY_KEY = 32'sd199999;

    typedef struct packed {
        logic       load;    // capture request word
        logic       exec;    // apply operation, register result
        logic [1:0] op;
        logic [1:0] status;
    } cmd_t;

    typedef struct packed {
        logic [1:0] action;
        logic       key_high;
        logic       full;
        logic       empty;
    } flags_t;

endpackage

// File: sv/mpq_ctrl.sv
// Request sequencer of the priority queue.
module mpq_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  mpq_pkg::flags_t flags,
    output mpq_pkg::cmd_t   cmd,
    output logic            busy,
    output logic            done
);
    import mpq_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic done_reg;
    logic done_next;
    logic [1:0] op;
    logic [1:0] st;

    always_comb
    begin
        op = OP_NONE;
        st = ST_OK;
        case (flags.action)
            ACT_INSERT:
            begin
                if (flags.key_high)
                    st = ST_REJECT;
                else if (flags.full)
                    st = ST_FULL;
                else
                    op = OP_PUT;
            end
            ACT_REMOVE:
            begin
                if (flags.empty)
                    st = ST_EMPTY;
                else
                    op = OP_TAKE;
            end
            default:
            begin
                op = OP_NONE;
                st = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign done_next  = (state_reg == S_EXEC);
    assign busy       = (state_reg == S_EXEC);
    assign cmd.load   = start && (state_reg == S_IDLE);
    assign cmd.exec   = (state_reg == S_EXEC);
    assign cmd.op     = op;
    assign cmd.status = st;
    assign done       = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

endmodule

// File: sv/mpq_dp.sv
// Sorted key cells, held count and result registers of the priority queue.
module mpq_dp #(
    parameter int CAPACITY = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  mpq_pkg::cmd_t      cmd,
    input  logic [1:0]         action,
    input  logic signed [31:0] key,
    output mpq_pkg::flags_t    flags,
    output logic signed [31:0] min_key,
    output logic               is_empty,
    output logic [6:0]         entry_count,
    output logic [1:0]         status
);
    import mpq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    logic [1:0]         action_reg;
    logic signed [31:0] key_reg;
    logic signed [31:0] cell_reg  [CAPACITY];
    logic signed [31:0] cell_next [CAPACITY];
    logic [CAPACITY-1:0] le;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [CW+6:0]      count_wide;
    logic signed [31:0] min_key_reg;
    logic               is_empty_reg;
    logic [6:0]         entry_count_reg;
    logic [1:0]         status_reg;

    // request word capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg <= action;
            key_reg    <= key;
        end
    end

    assign flags.action   = action_reg;
    assign flags.key_high = (key_reg >= EMPTY_KEY);
    assign flags.full     = (count_reg >= CAP_CNT);
    assign flags.empty    = (count_reg == '0);

    // one compare per cell; held cells form an ascending prefix
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        localparam logic [CW-1:0] IDX = CW'(i);
        logic signed [31:0] ins_val;
        logic signed [31:0] del_val;

        assign le[i] = (IDX < count_reg) && (cell_reg[i] <= key_reg);

        if (i == 0)
        begin : g_first
            assign ins_val = le[0] ? cell_reg[0] : key_reg;
        end
        else
        begin : g_rest
            assign ins_val = le[i] ? cell_reg[i] : (le[i-1] ? key_reg : cell_reg[i-1]);
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign del_val = cell_reg[i];
        end
        else
        begin : g_mid
            assign del_val = cell_reg[i+1];
        end

        always_comb
        begin
            case (cmd.op)
                OP_PUT:  cell_next[i] = ins_val;
                OP_TAKE: cell_next[i] = del_val;
                default: cell_next[i] = cell_reg[i];
            endcase
        end

        always_ff @(posedge clk)
        begin
            if (cmd.exec)
                cell_reg[i] <= cell_next[i];
        end
    end

    always_comb
    begin
        case (cmd.op)
            OP_PUT:  count_next = count_reg + CW'(1);
            OP_TAKE: count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    assign count_wide = {7'd0, count_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cmd.exec)
            count_reg <= count_next;
    end

    // result word
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            min_key_reg     <= (count_next == '0) ? EMPTY_KEY : cell_next[0];
            is_empty_reg    <= (count_next == '0);
            entry_count_reg <= count_wide[6:0];
            status_reg      <= cmd.status;
        end
    end

    assign min_key     = min_key_reg;
    assign is_empty    = is_empty_reg;
    assign entry_count = entry_count_reg;
    assign status      = status_reg;

endmodule

// File: sv/min_priority_queue.sv
// Top level of the bounded min-priority queue.
//
// Each request passes through the controller's capture and apply
// steps: start is sampled while busy is low, busy stays high for the
// one cycle in which the store is updated, and the result word appears
// with done high in the following cycle, when a new request may already
// be started. The whole sorted row of CAPACITY key cells compares and
// shifts in the apply cycle. Results are shown for exactly one
// cycle and cannot be held off, so the receiver must take every word when
// done is high. min_key reads 199999 on an empty queue; inserts of keys at
// or above that value are refused (status 3), inserts into a full queue are
// dropped (status 1), and removes from an empty queue report status 2.
// entry_count is the held count cut to 7 bits. There is no clearing pass
// after reset: key cells are only read below the held count.
`include "min_priority_queue_macros.svh"

module min_priority_queue #(
    parameter int CAPACITY = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         action,
    input  logic signed [31:0] key,
    output logic               done,
    output logic signed [31:0] min_key,
    output logic               is_empty,
    output logic [6:0]         entry_count,
    output logic [1:0]         status
);
    import mpq_pkg::*;

    cmd_t   cmd;    // controller -> datapath
    flags_t flags;  // datapath -> controller

    mpq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .flags (flags),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    mpq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .action      (action),
        .key         (key),
        .flags       (flags),
        .min_key     (min_key),
        .is_empty    (is_empty),
        .entry_count (entry_count),
        .status      (status)
    );

    // an accepted word is applied in the next cycle, not answered there
    `MPQ_ASSERT_NEXT(a_accept, clk, rst_n, start && !busy, busy && !done, "no apply cycle")
    // the apply cycle always yields a result word
    `MPQ_ASSERT_NEXT(a_busy_done, clk, rst_n, busy, done && !busy, "apply without result")
    // a held key can never equal the empty marker
    `MPQ_ASSERT_NOW(a_empty, clk, rst_n, done, is_empty == (min_key == EMPTY_KEY), "bad empty")

endmodule
